// File: sv/aeru_pkg.sv
// Shared types, operation codes and status codes of the adjacency edge remove/undo unit.
`default_nettype none

package aeru_pkg;

    // Field widths of one transaction on either channel
    localparam int OP_W   = 3;
    localparam int VTX_W  = 10;
    localparam int SLOT_W = 12;
    localparam int DEG_W  = 9;
    localparam int STAT_W = 2;

    // Raw operation codes as they arrive on the request channel
    localparam logic [OP_W-1:0] CODE_SET    = 3'd0;
    localparam logic [OP_W-1:0] CODE_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] CODE_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] CODE_UNDO   = 3'd3;
    localparam logic [OP_W-1:0] CODE_QUERY  = 3'd4;

    // Status codes of the response channel
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // Classified operation carried through the queue
    typedef enum logic [2:0] {
        OP_SET,
        OP_WRITE,
        OP_REMOVE,
        OP_UNDO,
        OP_QUERY,
        OP_NONE
    } t_op;

    // One queued request, fields already reduced into range
    typedef struct packed {
        t_op               op;
        logic [VTX_W-1:0]  u;
        logic [VTX_W-1:0]  v;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] part;
        logic [DEG_W-1:0]  deg;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_VRD_U,
        S_VRD_V,
        S_VCAP,
        S_SCAN,
        S_ENDRED,
        S_ULOAD,
        S_SW1,
        S_SW2,
        S_SW3,
        S_SW4,
        S_LINK1,
        S_LINK2,
        S_FIX1,
        S_FIX2,
        S_DEG1,
        S_DEG2,
        S_PUSH,
        S_RESP
    } t_bstate;

    // Map a raw code onto the classified operation
    function automatic t_op decode_op(input logic [OP_W-1:0] code);
        t_op op;
        case (code)
            CODE_SET:    op = OP_SET;
            CODE_WRITE:  op = OP_WRITE;
            CODE_REMOVE: op = OP_REMOVE;
            CODE_UNDO:   op = OP_UNDO;
            CODE_QUERY:  op = OP_QUERY;
            default:     op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// File: sv/aeru_if.sv
// Request and response channel interfaces of the adjacency edge remove/undo unit.
`default_nettype none

interface aeru_req_if;
    import aeru_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [VTX_W-1:0]  vertex_u;
    logic [VTX_W-1:0]  vertex_v;
    logic [SLOT_W-1:0] slot_index;
    logic [SLOT_W-1:0] partner_slot;
    logic [DEG_W-1:0]  degree;

    modport source (
        output valid, operation, vertex_u, vertex_v, slot_index, partner_slot, degree,
        input  ready
    );
    modport sink (
        input  valid, operation, vertex_u, vertex_v, slot_index, partner_slot, degree,
        output ready
    );
endinterface

interface aeru_rsp_if;
    import aeru_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic              found;

    modport source (output valid, status, found, input ready);
    modport sink (input valid, status, found, output ready);
endinterface

`default_nettype wire

// File: sv/aeru_front.sv
// Front end: accepts request transactions, reduces indexes into range and classifies them.
`default_nettype none

module aeru_front #(
    parameter int VERTICES = 1024,
    parameter int SLOTS    = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    aeru_req_if.sink       i_req,
    input  logic           i_q_full,
    output logic           o_push,
    output aeru_pkg::t_item o_item
);
    import aeru_pkg::*;

    logic  r_busy;
    t_item r_item;
    logic  w_accept;
    logic  w_u_hi, w_v_hi, w_s_hi, w_p_hi;
    logic  w_done;

    // Take a new transaction only when the holding stage is free
    assign i_req.ready = !r_busy;
    assign w_accept    = i_req.valid && !r_busy;

    // Fields still at or above their modulus
    assign w_u_hi = 32'(r_item.u) >= 32'(VERTICES);
    assign w_v_hi = 32'(r_item.v) >= 32'(VERTICES);
    assign w_s_hi = 32'(r_item.slot) >= 32'(SLOTS);
    assign w_p_hi = 32'(r_item.part) >= 32'(SLOTS);
    assign w_done = !(w_u_hi || w_v_hi || w_s_hi || w_p_hi);

    // Hand the reduced item to the queue
    assign o_push = r_busy && w_done && !i_q_full;
    assign o_item = r_item;

    // Hold flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (o_push) begin
            r_busy <= 1'b0;
        end
    end

    // Capture, then subtract the modulus until every index is in range
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op   <= decode_op(i_req.operation);
            r_item.u    <= i_req.vertex_u;
            r_item.v    <= i_req.vertex_v;
            r_item.slot <= i_req.slot_index;
            r_item.part <= i_req.partner_slot;
            r_item.deg  <= i_req.degree;
        end else if (r_busy) begin
            if (w_u_hi) begin
                r_item.u <= r_item.u - VTX_W'(VERTICES);
            end
            if (w_v_hi) begin
                r_item.v <= r_item.v - VTX_W'(VERTICES);
            end
            if (w_s_hi) begin
                r_item.slot <= r_item.slot - SLOT_W'(SLOTS);
            end
            if (w_p_hi) begin
                r_item.part <= r_item.part - SLOT_W'(SLOTS);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/aeru_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module aeru_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aeru_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output aeru_pkg::t_item o_item
);
    import aeru_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/aeru_back.sv
// Back end: sequencer that executes set, write, remove, undo and query on the graph memories.
`default_nettype none

module aeru_back #(
    parameter int VERTICES   = 1024,
    parameter int SLOTS      = 4096,
    parameter int MAX_DEGREE = 256,
    parameter int UNDO_DEPTH = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  aeru_pkg::t_item i_item,
    output logic            o_pop,
    aeru_rsp_if.source      o_rsp
);
    import aeru_pkg::*;

    localparam int VW   = $clog2(VERTICES);
    localparam int SW   = $clog2(SLOTS);
    localparam int DW   = $clog2(MAX_DEGREE + 1);
    localparam int UW   = $clog2(UNDO_DEPTH + 1);
    localparam int UIW  = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
    localparam int SUMW = ((SW > DW) ? SW : DW) + 1;
    localparam int RECW = VW + 2 * SW;

    // Memories
    logic [VW-1:0]   nb_mem   [SLOTS];
    logic [SW-1:0]   pt_mem   [SLOTS];
    logic [SW-1:0]   base_mem [VERTICES];
    logic [DW-1:0]   deg_mem  [VERTICES];
    logic [RECW-1:0] ua_mem   [UNDO_DEPTH];
    logic [RECW-1:0] ub_mem   [UNDO_DEPTH];

    // Memory ports
    logic [SW-1:0]   slot_raddr, slot_waddr;
    logic            nb_we, pt_we;
    logic [VW-1:0]   nb_wdata, nb_q;
    logic [SW-1:0]   pt_wdata, pt_q;
    logic [VW-1:0]   vtx_raddr, vtx_waddr;
    logic            base_we, deg_we;
    logic [SW-1:0]   base_wdata, base_q;
    logic [DW-1:0]   deg_wdata, deg_q;
    logic            undo_we;
    logic [UIW-1:0]  undo_raddr, undo_waddr;
    logic [RECW-1:0] ua_q, ub_q;

    // Sequencer and datapath registers
    t_bstate        r_state, n_state;
    t_op            r_op;
    logic [VW-1:0]  r_u, r_v;
    logic [SW-1:0]  r_bu, r_bv;
    logic [DW-1:0]  r_n, r_m;
    logic [VW-1:0]  r_va, r_vb;
    logic [SW-1:0]  r_pa, r_ea, r_pb, r_eb;
    logic [VW-1:0]  r_tgt;
    logic [SW-1:0]  r_p, r_cslot;
    logic [DW-1:0]  r_k, r_lim;
    logic           r_chk;
    logic           r_ph;
    logic [VW-1:0]  r_tn;
    logic [SW-1:0]  r_tp;
    logic [SUMW-1:0] r_sum_a, r_sum_b;
    logic [UW-1:0]  r_cnt;
    logic [STAT_W-1:0] r_status;
    logic           r_found;
    logic           r_ovalid;
    logic [STAT_W-1:0] r_ostatus;
    logic           r_ofound;

    // Combinational helpers
    logic [VW-1:0]  w_iu, w_iv;
    logic [UW-1:0]  w_cnt_m1;
    logic           w_undo, w_full, w_empty;
    logic           w_hit, w_issue, w_miss;
    logic [SW-1:0]  w_pnext;
    logic           w_a_hi, w_b_hi;
    logic [SW-1:0]  w_l1, w_l2, w_f1, w_f2;
    logic [DW-1:0]  w_set_deg;
    logic           w_load;
    logic [STAT_W-1:0] w_idle_status;

    assign w_iu      = VW'(i_item.u);
    assign w_iv      = VW'(i_item.v);
    assign w_cnt_m1  = r_cnt - UW'(1);
    assign w_undo    = r_op == OP_UNDO;
    assign w_full    = r_cnt == UW'(UNDO_DEPTH);
    assign w_empty   = r_cnt == '0;
    assign w_set_deg = (32'(i_item.deg) > 32'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(i_item.deg);

    // Slice scan: one read issued per cycle, compared in the cycle after
    assign w_issue = r_k < r_lim;
    assign w_hit   = r_chk && (nb_q == r_tgt);
    assign w_miss  = !w_hit && !r_chk && !w_issue;
    assign w_pnext = (r_p == SW'(SLOTS - 1)) ? '0 : r_p + SW'(1);

    // Slice end reduction
    assign w_a_hi = 32'(r_sum_a) >= 32'(SLOTS);
    assign w_b_hi = 32'(r_sum_b) >= 32'(SLOTS);

    // Removal links the slice ends and repairs through the found slots; undo the reverse
    assign w_l1 = w_undo ? r_pa : r_ea;
    assign w_l2 = w_undo ? r_pb : r_eb;
    assign w_f1 = w_undo ? r_ea : r_pa;
    assign w_f2 = w_undo ? r_eb : r_pb;

    assign w_load = (r_state == S_RESP) && (!r_ovalid || o_rsp.ready);

    // Status decided on dispatch
    always_comb begin
        w_idle_status = ST_OK;
        if (i_item.op == OP_REMOVE && i_item.u == i_item.v) begin
            w_idle_status = ST_NOT_FOUND;
        end else if (i_item.op == OP_UNDO && w_empty) begin
            w_idle_status = ST_EMPTY;
        end
    end

    // Slot memories
    always_ff @(posedge i_clk) begin
        if (nb_we) begin
            nb_mem[slot_waddr] <= nb_wdata;
        end
        nb_q <= nb_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[slot_waddr] <= pt_wdata;
        end
        pt_q <= pt_mem[slot_raddr];
    end

    // Vertex memories
    always_ff @(posedge i_clk) begin
        if (base_we) begin
            base_mem[vtx_waddr] <= base_wdata;
        end
        base_q <= base_mem[vtx_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[vtx_waddr] <= deg_wdata;
        end
        deg_q <= deg_mem[vtx_raddr];
    end

    // Undo stack memories
    assign undo_raddr = w_cnt_m1[UIW-1:0];
    assign undo_waddr = r_cnt[UIW-1:0];

    always_ff @(posedge i_clk) begin
        if (undo_we) begin
            ua_mem[undo_waddr] <= {r_va, r_pa, r_ea};
        end
        ua_q <= ua_mem[undo_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (undo_we) begin
            ub_mem[undo_waddr] <= {r_vb, r_pb, r_eb};
        end
        ub_q <= ub_mem[undo_raddr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_item.op)
                        OP_REMOVE: n_state = (i_item.u == i_item.v) ? S_RESP : S_VRD_U;
                        OP_UNDO:   n_state = w_empty ? S_RESP : S_ULOAD;
                        OP_QUERY:  n_state = S_VRD_U;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_VRD_U: n_state = S_VRD_V;
            S_VRD_V: n_state = S_VCAP;
            S_VCAP:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_hit) begin
                    if (r_op == OP_QUERY) begin
                        n_state = S_RESP;
                    end else if (!r_ph) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = w_full ? S_RESP : S_ENDRED;
                    end
                end else if (w_miss) begin
                    n_state = S_RESP;
                end
            end
            S_ENDRED: n_state = (!w_a_hi && !w_b_hi) ? S_SW1 : S_ENDRED;
            S_ULOAD:  n_state = S_SW1;
            S_SW1:    n_state = S_SW2;
            S_SW2:    n_state = S_SW3;
            S_SW3:    n_state = S_SW4;
            S_SW4:    n_state = r_ph ? S_LINK1 : S_SW1;
            S_LINK1:  n_state = S_LINK2;
            S_LINK2:  n_state = S_FIX1;
            S_FIX1:   n_state = S_FIX2;
            S_FIX2:   n_state = r_ph ? S_DEG1 : S_FIX1;
            S_DEG1:   n_state = S_DEG2;
            S_DEG2: begin
                if (!r_ph) begin
                    n_state = S_DEG1;
                end else begin
                    n_state = w_undo ? S_RESP : S_PUSH;
                end
            end
            S_PUSH:   n_state = S_RESP;
            S_RESP:   n_state = w_load ? S_IDLE : S_RESP;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory controls per state
    always_comb begin
        o_pop      = 1'b0;
        slot_raddr = r_p;
        slot_waddr = r_pa;
        nb_we      = 1'b0;
        pt_we      = 1'b0;
        nb_wdata   = nb_q;
        pt_wdata   = pt_q;
        vtx_raddr  = r_u;
        vtx_waddr  = r_va;
        base_we    = 1'b0;
        deg_we     = 1'b0;
        base_wdata = SW'(i_item.slot);
        deg_wdata  = w_set_deg;
        undo_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = i_valid;
                if (i_valid && i_item.op == OP_SET) begin
                    vtx_waddr = w_iu;
                    base_we   = 1'b1;
                    deg_we    = 1'b1;
                end
                if (i_valid && i_item.op == OP_WRITE) begin
                    slot_waddr = SW'(i_item.slot);
                    nb_we      = 1'b1;
                    pt_we      = 1'b1;
                    nb_wdata   = w_iv;
                    pt_wdata   = SW'(i_item.part);
                end
            end
            S_VRD_U: vtx_raddr = r_u;
            S_VRD_V: vtx_raddr = r_v;
            S_SW1:   slot_raddr = r_ph ? r_pb : r_pa;
            S_SW2:   slot_raddr = r_ph ? r_eb : r_ea;
            S_SW3: begin
                slot_waddr = r_ph ? r_pb : r_pa;
                nb_we      = 1'b1;
                pt_we      = 1'b1;
            end
            S_SW4: begin
                slot_waddr = r_ph ? r_eb : r_ea;
                nb_we      = 1'b1;
                pt_we      = 1'b1;
                nb_wdata   = r_tn;
                pt_wdata   = r_tp;
            end
            S_LINK1: begin
                slot_waddr = w_l1;
                pt_we      = 1'b1;
                pt_wdata   = w_l2;
            end
            S_LINK2: begin
                slot_waddr = w_l2;
                pt_we      = 1'b1;
                pt_wdata   = w_l1;
            end
            S_FIX1: slot_raddr = r_ph ? w_f2 : w_f1;
            S_FIX2: begin
                slot_waddr = pt_q;
                pt_we      = 1'b1;
                pt_wdata   = r_ph ? w_f2 : w_f1;
            end
            S_DEG1: vtx_raddr = r_ph ? r_vb : r_va;
            S_DEG2: begin
                vtx_waddr = r_ph ? r_vb : r_va;
                deg_we    = 1'b1;
                if (w_undo) begin
                    deg_wdata = (32'(deg_q) < 32'(MAX_DEGREE)) ? deg_q + DW'(1) : deg_q;
                end else begin
                    deg_wdata = deg_q - DW'(1);
                end
            end
            S_PUSH: undo_we = 1'b1;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid && i_item.op == OP_UNDO && !w_empty) begin
                r_cnt <= w_cnt_m1;
            end else if (r_state == S_PUSH) begin
                r_cnt <= r_cnt + UW'(1);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= i_item.op;
                r_u      <= w_iu;
                r_v      <= w_iv;
                r_status <= w_idle_status;
                r_found  <= 1'b0;
            end
            S_VRD_V: begin
                r_bu <= base_q;
                r_n  <= deg_q;
            end
            S_VCAP: begin
                r_bv  <= base_q;
                r_m   <= deg_q;
                r_p   <= r_bu;
                r_k   <= '0;
                r_lim <= r_n;
                r_tgt <= r_v;
                r_chk <= 1'b0;
                r_ph  <= 1'b0;
            end
            S_SCAN: begin
                r_chk <= w_issue;
                if (w_issue) begin
                    r_p     <= w_pnext;
                    r_k     <= r_k + DW'(1);
                    r_cslot <= r_p;
                end
                if (w_hit) begin
                    if (r_op == OP_QUERY) begin
                        r_found <= 1'b1;
                    end else if (!r_ph) begin
                        // Second endpoint: look for u in v's slice
                        r_pa  <= r_cslot;
                        r_p   <= r_bv;
                        r_k   <= '0;
                        r_lim <= r_m;
                        r_tgt <= r_u;
                        r_chk <= 1'b0;
                        r_ph  <= 1'b1;
                    end else begin
                        r_pb    <= r_cslot;
                        r_va    <= r_u;
                        r_vb    <= r_v;
                        r_sum_a <= SUMW'(r_bu) + SUMW'(r_n) - SUMW'(1);
                        r_sum_b <= SUMW'(r_bv) + SUMW'(r_m) - SUMW'(1);
                        r_ph    <= 1'b0;
                        if (w_full) begin
                            r_status <= ST_FULL;
                        end
                    end
                end else if (w_miss && r_op != OP_QUERY) begin
                    r_status <= ST_NOT_FOUND;
                end
            end
            S_ENDRED: begin
                if (w_a_hi) begin
                    r_sum_a <= r_sum_a - SUMW'(SLOTS);
                end
                if (w_b_hi) begin
                    r_sum_b <= r_sum_b - SUMW'(SLOTS);
                end
                r_ea <= SW'(r_sum_a);
                r_eb <= SW'(r_sum_b);
            end
            S_ULOAD: begin
                {r_va, r_pa, r_ea} <= ua_q;
                {r_vb, r_pb, r_eb} <= ub_q;
                r_ph <= 1'b0;
            end
            S_SW2: begin
                r_tn <= nb_q;
                r_tp <= pt_q;
            end
            S_SW4:  r_ph <= !r_ph;
            S_LINK2: r_ph <= 1'b0;
            S_FIX2: r_ph <= !r_ph;
            S_DEG2: r_ph <= !r_ph;
            default: ;
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ostatus <= r_status;
            r_ofound  <= r_found;
        end
    end

    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.status = r_ostatus;
    assign o_rsp.found  = r_ofound;

endmodule

`default_nettype wire

// File: sv/adjacency_edge_remove_undo_unit.sv
// Top level of the adjacency edge remove/undo unit.
// The unit keeps an undirected graph as per-vertex neighbor slices with partner slots, a live
// degree per vertex and an undo stack, all in on-chip memories with registered reads. Every
// request transaction yields exactly one response transaction (status, found). The front end
// takes a request, reduces its indexes into range (one subtract per cycle, none needed at the
// default sizes) and queues it; the back-end sequencer owns all memory ports and runs one request
// at a time. Query scans the slice of u and remove the slices of u and v, reading one slot per
// cycle on the slot memory port. A finished response waits in an output register while
// the front end keeps accepting into the two-entry queue. No memory is cleared after reset:
// entries read before they are written return arbitrary values.
`default_nettype none

module adjacency_edge_remove_undo_unit #(
    parameter int VERTICES   = 1024,
    parameter int SLOTS      = 4096,
    parameter int MAX_DEGREE = 256,
    parameter int UNDO_DEPTH = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    aeru_req_if.sink   i_req,
    aeru_rsp_if.source o_rsp
);
    import aeru_pkg::*;

    logic  w_push;
    logic  w_q_full;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_front_item;
    t_item w_q_item;

    // Accept and classify
    aeru_front #(
        .VERTICES (VERTICES),
        .SLOTS    (SLOTS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    // Decouple front and back
    aeru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Execute against the graph memories
    aeru_back #(
        .VERTICES   (VERTICES),
        .SLOTS      (SLOTS),
        .MAX_DEGREE (MAX_DEGREE),
        .UNDO_DEPTH (UNDO_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

    // Never push into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full queue");

    // Never pop an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("pop from empty queue");

    // A live edge is only reported with ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> (o_rsp.status == ST_OK))
        else $error("found set with error status");

endmodule

`default_nettype wire

// File: bench/aeru_checker.sv
// Response checker of the adjacency edge remove/undo unit: tracks the graph, predicts and compares.
module aeru_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    aeru_req_if  i_req,
    aeru_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import aeru_pkg::*;

    localparam int SLOT_N   = 4096;
    localparam int DEG_CAP  = 256;
    localparam int STACK_N  = 2048;
    localparam int REPORT_N = 10;

    typedef struct packed {
        logic [VTX_W-1:0]  vtx;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] tail;
    } t_removal;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
    } t_reply;

    // Shadow copy of the graph and the removal stack
    bit [VTX_W-1:0]  nbr_mem   [SLOT_N];
    bit [SLOT_W-1:0] prt_mem   [SLOT_N];
    bit [SLOT_W-1:0] base_mem  [1024];
    bit [DEG_W-1:0]  deg_mem   [1024];
    t_removal        first_half  [STACK_N];
    t_removal        second_half [STACK_N];
    int              stack_depth = 0;

    t_reply reply_q[$];
    int     fail_count = 0;
    int     reply_seen = 0;

    // Offset of w within the live slice of a, or the live degree when absent
    function automatic int scan_slice(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] w);
        int i;
        logic [SLOT_W-1:0] s;
        for (i = 0; i < deg_mem[a]; i++) begin
            s = base_mem[a] + SLOT_W'(i);
            if (nbr_mem[s] == w) break;
        end
        return i;
    endfunction

    function automatic void swap_entries(input logic [SLOT_W-1:0] p, input logic [SLOT_W-1:0] q);
        logic [VTX_W-1:0]  tn;
        logic [SLOT_W-1:0] tp;
        tn = nbr_mem[p];
        nbr_mem[p] = nbr_mem[q];
        nbr_mem[q] = tn;
        tp = prt_mem[p];
        prt_mem[p] = prt_mem[q];
        prt_mem[q] = tp;
    endfunction

    function automatic logic [STAT_W-1:0] remove_edge_pair(input logic [VTX_W-1:0] u,
                                                           input logic [VTX_W-1:0] v);
        int n, m, i, j;
        logic [SLOT_W-1:0] x, xe, y, ye;
        if (u == v) return ST_NOT_FOUND;
        n = deg_mem[u];
        m = deg_mem[v];
        i = scan_slice(u, v);
        if (i >= n) return ST_NOT_FOUND;
        j = scan_slice(v, u);
        if (j >= m) return ST_NOT_FOUND;
        if (stack_depth >= STACK_N) return ST_FULL;
        x  = base_mem[u] + SLOT_W'(i);
        xe = base_mem[u] + SLOT_W'(n - 1);
        y  = base_mem[v] + SLOT_W'(j);
        ye = base_mem[v] + SLOT_W'(m - 1);
        swap_entries(x, xe);
        swap_entries(y, ye);
        prt_mem[xe] = ye;
        prt_mem[ye] = xe;
        prt_mem[prt_mem[x]] = x;
        prt_mem[prt_mem[y]] = y;
        deg_mem[u] = DEG_W'(n - 1);
        deg_mem[v] = DEG_W'(m - 1);
        first_half[stack_depth]  = '{u, x, xe};
        second_half[stack_depth] = '{v, y, ye};
        stack_depth++;
        return ST_OK;
    endfunction

    function automatic logic [STAT_W-1:0] restore_last_removal();
        t_removal a, b;
        if (stack_depth == 0) return ST_EMPTY;
        stack_depth--;
        a = first_half[stack_depth];
        b = second_half[stack_depth];
        swap_entries(a.pos, a.tail);
        swap_entries(b.pos, b.tail);
        prt_mem[a.pos] = b.pos;
        prt_mem[b.pos] = a.pos;
        prt_mem[prt_mem[a.tail]] = a.tail;
        prt_mem[prt_mem[b.tail]] = b.tail;
        if (deg_mem[a.vtx] < DEG_CAP) deg_mem[a.vtx]++;
        if (deg_mem[b.vtx] < DEG_CAP) deg_mem[b.vtx]++;
        return ST_OK;
    endfunction

    // Apply one request to the shadow graph and return the reply it must produce
    function automatic t_reply apply_request();
        t_reply r;
        r = '{ST_OK, 1'b0};
        case (i_req.operation)
            CODE_SET: begin
                base_mem[i_req.vertex_u] = i_req.slot_index;
                deg_mem[i_req.vertex_u]  = (i_req.degree > DEG_CAP) ? DEG_W'(DEG_CAP)
                                                                    : i_req.degree;
            end
            CODE_WRITE: begin
                nbr_mem[i_req.slot_index] = i_req.vertex_v;
                prt_mem[i_req.slot_index] = i_req.partner_slot;
            end
            CODE_REMOVE: r.status = remove_edge_pair(i_req.vertex_u, i_req.vertex_v);
            CODE_UNDO:   r.status = restore_last_removal();
            CODE_QUERY:  r.found  = (scan_slice(i_req.vertex_u, i_req.vertex_v)
                                     < deg_mem[i_req.vertex_u]);
            default: ;
        endcase
        return r;
    endfunction

    // Retire responses first, then record the request taken on the same edge
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                reply_seen++;
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_N)
                        $display("response %0d arrived with nothing outstanding: status %0d found %0d",
                                 reply_seen, i_rsp.status, i_rsp.found);
                end else begin
                    want = reply_q.pop_front();
                    if (want.status !== i_rsp.status || want.found !== i_rsp.found) begin
                        fail_count++;
                        if (fail_count <= REPORT_N)
                            $display("response %0d: expected status %0d found %0d, got status %0d found %0d",
                                     reply_seen, want.status, want.found,
                                     i_rsp.status, i_rsp.found);
                    end
                end
            end
            if (i_req.valid && i_req.ready) reply_q.push_back(apply_request());
        end
        o_pending    <= reply_q.size();
        o_fail_count <= fail_count;
    end

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end
endmodule

// File: bench/tb_adjacency_edge_remove_undo_unit.sv
// Stimulus and verdict for the adjacency edge remove/undo unit.
module tb_adjacency_edge_remove_undo_unit;
    import aeru_pkg::*;

    localparam int WINDOW     = 440;
    localparam int WIN_START  = 4032;
    localparam int POOL_N     = 12;
    localparam int HALF_N     = 432;
    localparam int RANDOM_N   = 1150;
    localparam int FILL_N     = 2100;
    localparam int DRAIN_WAIT = 400;
    localparam int CYCLE_CAP  = 4000000;
    localparam logic [OP_W-1:0] CODE_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] CODE_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count, pending, cycle_count = 0;
    bit   calm_send, calm_recv;

    aeru_req_if req_ch();
    aeru_rsp_if rsp_ch();

    adjacency_edge_remove_undo_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    aeru_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Graph layout: pool vertices, the dedicated pair and scratch vertices
    logic [VTX_W-1:0]  pool_vtx [POOL_N];
    int                pool_k   [POOL_N];
    int                pool_deg [POOL_N];
    logic [VTX_W-1:0]  pair_a, pair_b;
    logic [VTX_W-1:0]  window_nbr [WINDOW];
    logic [VTX_W-1:0]  scratch_q[$];
    bit                taken [1024];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("adjacency_edge_remove_undo_unit test failed");
            $finish;
        end
    end

    function automatic logic [SLOT_W-1:0] window_slot(input int k);
        return SLOT_W'((WIN_START + k) % 4096);
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic logic [VTX_W-1:0] fresh_vertex();
        logic [VTX_W-1:0] w;
        do w = $urandom_range(0, 1023); while (taken[w]);
        taken[w] = 1'b1;
        return w;
    endfunction

    // Send one request transaction after a random gap; valid stays up between back-to-back ones
    task automatic issue_request(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] u,
                                 input logic [VTX_W-1:0] v, input logic [SLOT_W-1:0] slot,
                                 input logic [SLOT_W-1:0] part, input logic [DEG_W-1:0] dg);
        int gap;
        gap = draw_gap(calm_send);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.vertex_u     <= u;
        req_ch.vertex_v     <= v;
        req_ch.slot_index   <= slot;
        req_ch.partner_slot <= part;
        req_ch.degree       <= dg;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic set_pool(input int p, input int dg);
        issue_request(CODE_SET, pool_vtx[p], $urandom, window_slot(pool_k[p]), $urandom, dg);
    endtask

    task automatic set_pair();
        issue_request(CODE_SET, pair_a, $urandom, window_slot(256), $urandom, 4);
        issue_request(CODE_SET, pair_b, $urandom, window_slot(260), $urandom, 4);
    endtask

    // Build the slices: shuffle pool half-edges and join them two by two
    task automatic load_graph();
        int he_k [HALF_N];
        logic [VTX_W-1:0] he_v [HALF_N];
        int n, t, r;
        logic [VTX_W-1:0] tv;
        n = 0;
        for (int p = 0; p < POOL_N; p++)
            for (int i = 0; i < pool_deg[p]; i++) begin
                he_k[n] = pool_k[p] + i;
                he_v[n] = pool_vtx[p];
                n++;
            end
        for (int i = HALF_N - 1; i > 0; i--) begin
            r = $urandom_range(0, i);
            t = he_k[i]; he_k[i] = he_k[r]; he_k[r] = t;
            tv = he_v[i]; he_v[i] = he_v[r]; he_v[r] = tv;
        end
        for (int i = 0; i < HALF_N; i += 2) begin
            window_nbr[he_k[i]]   = he_v[i + 1];
            window_nbr[he_k[i+1]] = he_v[i];
            issue_request(CODE_WRITE, $urandom, he_v[i + 1], window_slot(he_k[i]),
                          window_slot(he_k[i + 1]), $urandom);
            issue_request(CODE_WRITE, $urandom, he_v[i], window_slot(he_k[i + 1]),
                          window_slot(he_k[i]), $urandom);
        end
        // Parallel edges between the dedicated pair
        for (int i = 0; i < 4; i++) begin
            issue_request(CODE_WRITE, $urandom, pair_b, window_slot(256 + i),
                          window_slot(260 + i), $urandom);
            issue_request(CODE_WRITE, $urandom, pair_a, window_slot(260 + i),
                          window_slot(256 + i), $urandom);
        end
        set_pool(0, 300);
        for (int p = 1; p < POOL_N; p++) set_pool(p, pool_deg[p]);
        set_pair();
    endtask

    task automatic random_request();
        int pick, k, dg;
        logic [VTX_W-1:0] u, v;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            u = pool_vtx[$urandom_range(0, POOL_N - 1)];
            v = ($urandom_range(0, 9) == 0) ? u : pool_vtx[$urandom_range(0, POOL_N - 1)];
            issue_request(CODE_REMOVE, u, v, $urandom, $urandom, $urandom);
        end else if (pick < 45) begin
            issue_request(CODE_UNDO, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (pick < 70) begin
            k = $urandom_range(0, 9);
            if (k < 6)                               u = pool_vtx[$urandom_range(0, POOL_N - 1)];
            else if (k < 8 && scratch_q.size() > 0) u = scratch_q[$urandom_range(0, scratch_q.size() - 1)];
            else                                     u = k[0] ? pair_a : pair_b;
            v = ($urandom_range(0, 9) < 7) ? pool_vtx[$urandom_range(0, POOL_N - 1)]
                                           : VTX_W'($urandom);
            issue_request(CODE_QUERY, u, v, $urandom, $urandom, $urandom);
        end else if (pick < 82) begin
            // Keep the dedicated pair's slots intact; writes elsewhere are free
            if ($urandom_range(0, 1)) begin
                do k = $urandom_range(0, WINDOW - 1); while (k >= 256 && k < 264);
                issue_request(CODE_WRITE, $urandom, $urandom, window_slot(k), $urandom, $urandom);
            end else begin
                issue_request(CODE_WRITE, $urandom, $urandom,
                              $urandom_range(WINDOW - (4096 - WIN_START), WIN_START - 1),
                              $urandom, $urandom);
            end
        end else if (pick < 90) begin
            if (scratch_q.size() < 16 || $urandom_range(0, 1)) begin
                u = fresh_vertex();
                scratch_q.push_back(u);
            end else begin
                u = scratch_q[$urandom_range(0, scratch_q.size() - 1)];
            end
            dg = $urandom_range(0, 64);
            issue_request(CODE_SET, u, $urandom, window_slot($urandom_range(0, WINDOW - dg)),
                          $urandom, dg);
        end else begin
            issue_request($urandom_range(CODE_SPARE_LO, CODE_SPARE_HI),
                          $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Response side: random stalls with calm stretches
    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        forever begin
            stall = draw_gap(calm_recv);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
        end
    end

    // Flip the calm stretches now and then
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) calm_send <= ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 299) == 0) calm_recv <= ($urandom_range(0, 3) == 0);
    end

    initial begin
        int k0;
        i_rst_n             <= 1'b0;
        calm_send           <= 1'b0;
        calm_recv           <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.operation    <= CODE_SET;
        req_ch.vertex_u     <= '0;
        req_ch.vertex_v     <= '0;
        req_ch.slot_index   <= '0;
        req_ch.partner_slot <= '0;
        req_ch.degree       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Layout: widest vertex first so its slice wraps past the top slot
        pool_vtx[0] = 10'd1023; taken[1023] = 1'b1;
        pool_vtx[1] = 10'd0;    taken[0]    = 1'b1;
        for (int p = 2; p < POOL_N; p++) pool_vtx[p] = fresh_vertex();
        pair_a = fresh_vertex();
        pair_b = fresh_vertex();
        pool_k[0] = 0;
        pool_deg[0] = 256;
        for (int p = 1; p < POOL_N; p++) begin
            pool_k[p]   = 264 + 16 * (p - 1);
            pool_deg[p] = 16;
        end

        // Empty stack and unused codes with extreme fields
        issue_request(CODE_UNDO, '0, '0, '0, '0, '0);
        issue_request(CODE_SPARE_LO, '1, '1, '1, '1, '1);
        issue_request(3'd6, '0, '0, '0, '0, '0);
        issue_request(CODE_SPARE_HI, '1, '0, '1, '0, '1);
        issue_request(CODE_WRITE, '1, '1, '1, '1, '1);

        load_graph();

        // Queries, self loop, missing edge, removal and undo on the pair
        issue_request(CODE_QUERY, pair_a, pair_b, '0, '0, '0);
        issue_request(CODE_QUERY, pair_a, pair_a, '0, '0, '0);
        issue_request(CODE_QUERY, pool_vtx[0], window_nbr[255], '1, '1, '1);
        issue_request(CODE_REMOVE, pool_vtx[1], pool_vtx[1], '0, '0, '0);
        issue_request(CODE_REMOVE, pair_a, pool_vtx[0], '0, '0, '0);
        issue_request(CODE_REMOVE, pair_a, pair_b, '0, '0, '0);
        issue_request(CODE_QUERY, pair_b, pair_a, '0, '0, '0);
        issue_request(CODE_UNDO, '0, '0, '0, '0, '0);

        // Degree saturation on set and on undo
        k0 = 0;
        while (k0 < 255 && window_nbr[k0] == pool_vtx[0]) k0++;
        issue_request(CODE_REMOVE, pool_vtx[0], window_nbr[k0], '0, '0, '0);
        set_pool(0, 511);
        issue_request(CODE_UNDO, '1, '1, '1, '1, '1);
        issue_request(CODE_QUERY, pool_vtx[0], window_nbr[k0], '0, '0, '0);
        issue_request(CODE_SET, fresh_vertex(), '0, window_slot(0), '0, '0);

        repeat (RANDOM_N) random_request();

        // Fill the stack by removing the pair edge and restoring both degrees each time
        for (int i = 0; i < FILL_N; i++) begin
            set_pair();
            issue_request(CODE_REMOVE, pair_a, pair_b, $urandom, $urandom, $urandom);
        end
        set_pair();
        issue_request(CODE_REMOVE, pair_b, pair_a, '0, '0, '0);
        for (int i = 0; i < 8; i++) begin
            issue_request(CODE_UNDO, $urandom, $urandom, $urandom, $urandom, $urandom);
            set_pair();
        end

        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("adjacency_edge_remove_undo_unit test passed");
        else
            $display("adjacency_edge_remove_undo_unit test failed");
        $finish;
    end
endmodule

// File: filelist.f
sv/aeru_pkg.sv
sv/aeru_if.sv
sv/aeru_front.sv
sv/aeru_queue.sv
sv/aeru_back.sv
sv/adjacency_edge_remove_undo_unit.sv
bench/aeru_checker.sv
bench/tb_adjacency_edge_remove_undo_unit.sv
